// ===== rtl/v3a_pkg.sv =====
// Shared types of the 3D vector ALU.
package v3a_pkg;

   typedef enum logic [2:0] {
      MODE_ADD   = 3'd0,
      MODE_SUB   = 3'd1,
      MODE_SCALE = 3'd2,
      MODE_DOT   = 3'd3,
      MODE_CROSS = 3'd4,
      MODE_MAG   = 3'd5,
      MODE_DIST  = 3'd6
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
   } ctl_type;

endpackage

// ===== rtl/v3a_req_if.sv =====
// Request channel of the 3D vector ALU.
interface v3a_req_if #(parameter int WORD_BITS = 32) ();
   logic                        valid;
   logic                        ready;
   logic [2:0]                  mode;
   logic signed [WORD_BITS-1:0] a_i;
   logic signed [WORD_BITS-1:0] a_j;
   logic signed [WORD_BITS-1:0] a_k;
   logic signed [WORD_BITS-1:0] b_i;
   logic signed [WORD_BITS-1:0] b_j;
   logic signed [WORD_BITS-1:0] b_k;
   logic signed [WORD_BITS-1:0] scale_factor;

   modport source (output valid, mode, a_i, a_j, a_k, b_i, b_j, b_k, scale_factor,
                   input ready);
   modport sink (input valid, mode, a_i, a_j, a_k, b_i, b_j, b_k, scale_factor,
                 output ready);
endinterface

// ===== rtl/v3a_rsp_if.sv =====
// Response channel of the 3D vector ALU.
interface v3a_rsp_if #(parameter int WORD_BITS = 32) ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] out_i;
   logic signed [WORD_BITS-1:0] out_j;
   logic signed [WORD_BITS-1:0] out_k;
   logic                        saturated;

   modport source (output valid, out_i, out_j, out_k, saturated, input ready);
   modport sink (input valid, out_i, out_j, out_k, saturated, output ready);
endinterface

// ===== rtl/vector3d_alu.sv =====
// Top level of the 3D vector ALU: operand select, multiply, combine, root, clip.
//
//   channel   direction   transfer condition
//   req_ch    in          req_ch.valid && req_ch.ready
//   rsp_ch    out         rsp_ch.valid && rsp_ch.ready
//
// One item enters per cycle unless a response waits and is not taken; the square root
// pipeline resolves one root bit per stage.
// Reset clears every stage valid bit; payload registers are not reset.
// The whole pipeline holds while a response waits and is not taken.
module vector3d_alu #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   v3a_req_if.sink    req_ch,
   v3a_rsp_if.source  rsp_ch
);

   localparam int W  = WORD_BITS;
   localparam int RW = 2*WORD_BITS+4;
   localparam logic signed [RW-1:0] MAXV = (RW'(1) <<< (W-1)) - RW'(1);
   localparam logic signed [RW-1:0] MINV = -(RW'(1) <<< (W-1));

   logic adv;

   logic signed [W:0]      ea [3];
   logic signed [W:0]      eb [3];
   logic signed [W:0]      ed [3];
   logic signed [W:0]      es;
   logic signed [W:0]      x_in [6];
   logic signed [W:0]      y_in [6];
   logic signed [W:0]      v_in [3];
   logic signed [W:0]      x_ff [6];
   logic signed [W:0]      y_ff [6];
   logic signed [W:0]      v_ff [3];
   v3a_pkg::ctl_type       ctl_in;
   v3a_pkg::ctl_type       ctl0_ff;

   v3a_pkg::ctl_type       ctl1;
   logic signed [2*W+1:0]  p1 [6];
   logic signed [W:0]      v1 [3];
   v3a_pkg::ctl_type       ctl2;
   logic signed [RW-1:0]   r2 [3];
   logic [2*W+1:0]         sq2;
   v3a_pkg::ctl_type       ctl3;
   logic signed [RW-1:0]   r3 [3];
   logic [W:0]             root3;

   logic signed [RW-1:0]   fin [3];
   logic signed [W-1:0]    out_in [3];
   logic                   sat_in;
   logic signed [W-1:0]    out_ff [3];
   logic                   sat_ff;
   logic                   valid_ff;

   assign adv          = !valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_comb begin
      ea[0] = {req_ch.a_i[W-1], req_ch.a_i};
      ea[1] = {req_ch.a_j[W-1], req_ch.a_j};
      ea[2] = {req_ch.a_k[W-1], req_ch.a_k};
      eb[0] = {req_ch.b_i[W-1], req_ch.b_i};
      eb[1] = {req_ch.b_j[W-1], req_ch.b_j};
      eb[2] = {req_ch.b_k[W-1], req_ch.b_k};
      es    = {req_ch.scale_factor[W-1], req_ch.scale_factor};
      ctl_in.valid = req_ch.valid;
      ctl_in.mode  = v3a_pkg::mode_type'(req_ch.mode);
      for (int c = 0; c < 3; c++) begin
         ed[c]   = ea[c] - eb[c];
         v_in[c] = '0;
      end
      for (int n = 0; n < 6; n++) begin
         x_in[n] = '0;
         y_in[n] = '0;
      end
      case (ctl_in.mode)
         v3a_pkg::MODE_ADD: begin
            for (int c = 0; c < 3; c++) begin
               v_in[c] = ea[c] + eb[c];
            end
         end
         v3a_pkg::MODE_SUB: begin
            v_in = ed;
         end
         v3a_pkg::MODE_SCALE: begin
            for (int c = 0; c < 3; c++) begin
               x_in[c] = ea[c];
               y_in[c] = es;
            end
         end
         v3a_pkg::MODE_DOT: begin
            for (int c = 0; c < 3; c++) begin
               x_in[c] = ea[c];
               y_in[c] = eb[c];
            end
         end
         v3a_pkg::MODE_CROSS: begin
            x_in[0] = ea[1]; y_in[0] = eb[2];
            x_in[1] = ea[2]; y_in[1] = eb[1];
            x_in[2] = ea[2]; y_in[2] = eb[0];
            x_in[3] = ea[0]; y_in[3] = eb[2];
            x_in[4] = ea[0]; y_in[4] = eb[1];
            x_in[5] = ea[1]; y_in[5] = eb[0];
         end
         v3a_pkg::MODE_MAG: begin
            for (int c = 0; c < 3; c++) begin
               x_in[c] = ea[c];
               y_in[c] = ea[c];
            end
         end
         v3a_pkg::MODE_DIST: begin
            for (int c = 0; c < 3; c++) begin
               x_in[c] = ed[c];
               y_in[c] = ed[c];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl0_ff.valid <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl0_ff.mode <= ctl_in.mode;
         x_ff <= x_in;
         y_ff <= y_in;
         v_ff <= v_in;
      end
   end

   v3a_mul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock(clock), .reset(reset), .adv(adv),
      .ctl(ctl0_ff), .x(x_ff), .y(y_ff), .v(v_ff),
      .ctl_ff(ctl1), .p_ff(p1), .v_ff(v1)
   );

   v3a_comb #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_comb (
      .clock(clock), .reset(reset), .adv(adv),
      .ctl(ctl1), .p(p1), .v(v1),
      .ctl_ff(ctl2), .r_ff(r2), .sq_ff(sq2)
   );

   v3a_sqrt #(.WORD_BITS(WORD_BITS)) u_sqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .ctl(ctl2), .r(r2), .sq(sq2),
      .ctl_out(ctl3), .r_out(r3), .root_out(root3)
   );

   always_comb begin
      fin = r3;
      if (ctl3.mode == v3a_pkg::MODE_MAG || ctl3.mode == v3a_pkg::MODE_DIST) begin
         fin[0] = RW'(root3);
      end
      sat_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (fin[c] > MAXV) begin
            out_in[c] = MAXV[W-1:0];
            sat_in    = 1'b1;
         end else if (fin[c] < MINV) begin
            out_in[c] = MINV[W-1:0];
            sat_in    = 1'b1;
         end else begin
            out_in[c] = fin[c][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl3.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_i     = out_ff[0];
   assign rsp_ch.out_j     = out_ff[1];
   assign rsp_ch.out_k     = out_ff[2];
   assign rsp_ch.saturated = sat_ff;

   // A clipped result always sits on one of the word bounds.
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturated |->
         rsp_ch.out_i == MAXV[W-1:0] || rsp_ch.out_i == MINV[W-1:0] ||
         rsp_ch.out_j == MAXV[W-1:0] || rsp_ch.out_j == MINV[W-1:0] ||
         rsp_ch.out_k == MAXV[W-1:0] || rsp_ch.out_k == MINV[W-1:0])
      else $error("saturated flag without a clipped component");

   // The pipeline only stalls behind a response that is not taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.ready)
      else $error("input held off without an output stall");

   // Nothing leaves the pipeline straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

endmodule

// ===== rtl/v3a_mul.sv =====
// Multiplier stage: six signed products registered.
module v3a_mul #(
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  v3a_pkg::ctl_type             ctl,
   input  logic signed [WORD_BITS:0]    x [6],
   input  logic signed [WORD_BITS:0]    y [6],
   input  logic signed [WORD_BITS:0]    v [3],
   output v3a_pkg::ctl_type             ctl_ff,
   output logic signed [2*WORD_BITS+1:0] p_ff [6],
   output logic signed [WORD_BITS:0]    v_ff [3]
);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff.mode <= ctl.mode;
         for (int n = 0; n < 6; n++) begin
            p_ff[n] <= x[n] * y[n];
         end
         for (int c = 0; c < 3; c++) begin
            v_ff[c] <= v[c];
         end
      end
   end

endmodule

// ===== rtl/v3a_comb.sv =====
// Combine stage: sums of products, rounding and the sum of squares.
module v3a_comb #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  v3a_pkg::ctl_type              ctl,
   input  logic signed [2*WORD_BITS+1:0] p [6],
   input  logic signed [WORD_BITS:0]     v [3],
   output v3a_pkg::ctl_type              ctl_ff,
   output logic signed [2*WORD_BITS+3:0] r_ff [3],
   output logic [2*WORD_BITS+1:0]        sq_ff
);

   localparam int RW = 2*WORD_BITS+4;
   localparam int SB = 2*WORD_BITS+2;
   localparam logic signed [RW-1:0] HALF = (RW'(1) << FRAC_BITS) >>> 1;

   logic signed [RW-1:0] e [6];
   logic signed [RW-1:0] r_in [3];
   logic signed [RW-1:0] sum3;
   logic [SB-1:0]        sq_in;

   function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] x);
      logic signed [RW-1:0] t;
      t = x + HALF;
      return t >>> FRAC_BITS;
   endfunction

   always_comb begin
      for (int n = 0; n < 6; n++) begin
         e[n] = RW'(p[n]);
      end
      sum3 = e[0] + e[1] + e[2];
      sq_in = sum3[SB-1:0];
      for (int c = 0; c < 3; c++) begin
         r_in[c] = '0;
      end
      case (ctl.mode)
         v3a_pkg::MODE_ADD, v3a_pkg::MODE_SUB: begin
            for (int c = 0; c < 3; c++) begin
               r_in[c] = RW'(v[c]);
            end
         end
         v3a_pkg::MODE_SCALE: begin
            for (int c = 0; c < 3; c++) begin
               r_in[c] = rnd(e[c]);
            end
         end
         v3a_pkg::MODE_DOT: begin
            r_in[0] = rnd(sum3);
         end
         v3a_pkg::MODE_CROSS: begin
            r_in[0] = rnd(e[0] - e[1]);
            r_in[1] = rnd(e[2] - e[3]);
            r_in[2] = rnd(e[4] - e[5]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff.mode <= ctl.mode;
         r_ff <= r_in;
         sq_ff <= sq_in;
      end
   end

endmodule

// ===== rtl/v3a_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module v3a_sqrt #(
   parameter int WORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  v3a_pkg::ctl_type              ctl,
   input  logic signed [2*WORD_BITS+3:0] r [3],
   input  logic [2*WORD_BITS+1:0]        sq,
   output v3a_pkg::ctl_type              ctl_out,
   output logic signed [2*WORD_BITS+3:0] r_out [3],
   output logic [WORD_BITS:0]            root_out
);

   localparam int RB = WORD_BITS+1;
   localparam int SB = 2*RB;
   localparam int RM = RB+3;
   localparam int RW = 2*WORD_BITS+4;

   v3a_pkg::ctl_type     ctl_ff  [RB];
   logic signed [RW-1:0] r_ff    [RB][3];
   logic [SB-1:0]        sq_ff   [RB];
   logic [RM-1:0]        rem_ff  [RB];
   logic [RB-1:0]        root_ff [RB];

   for (genvar k = 0; k < RB; k++) begin : g_stage
      v3a_pkg::ctl_type     ctl_src;
      logic signed [RW-1:0] r_src [3];
      logic [SB-1:0]        sq_src;
      logic [RM-1:0]        rem_src;
      logic [RB-1:0]        root_src;
      logic [RM-1:0]        cur;
      logic [RM-1:0]        trial;
      logic [RM-1:0]        rem_in;
      logic [RB-1:0]        root_in;

      if (k == 0) begin : g_first
         assign ctl_src  = ctl;
         assign r_src    = r;
         assign sq_src   = sq;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign ctl_src  = ctl_ff[k-1];
         assign r_src    = r_ff[k-1];
         assign sq_src   = sq_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         cur   = {rem_src[RM-3:0], sq_src[2*(RB-1-k)+1 -: 2]};
         trial = {1'b0, root_src, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_src[RB-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_src[RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k].valid <= ctl_src.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctl_ff[k].mode <= ctl_src.mode;
            r_ff[k]        <= r_src;
            sq_ff[k]       <= sq_src;
            rem_ff[k]      <= rem_in;
            root_ff[k]     <= root_in;
         end
      end
   end

   assign ctl_out  = ctl_ff[RB-1];
   assign r_out    = r_ff[RB-1];
   assign root_out = root_ff[RB-1];

endmodule

// ===== sim/tb_vector3d_alu.sv =====
// Testbench of the 3D vector ALU: directed table and random items against a predictor.
`timescale 1ns / 100ps

module tb_vector3d_alu;

   localparam int W = 32;
   localparam int F = 16;
   localparam int LATENCY = W + 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [W-1:0] WMAX = 32'sh7fffffff;
   localparam logic signed [W-1:0] WMIN = 32'sh80000000;

   typedef struct {
      logic [2:0]          mode;
      logic signed [W-1:0] a [3];
      logic signed [W-1:0] b [3];
      logic signed [W-1:0] sf;
   } op_type;

   typedef struct {
      logic signed [W-1:0] v [3];
      logic                sat;
   } result_type;

   typedef struct {
      op_type     op;
      logic       known;
      result_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   errors = 0;
   int   send_idle_pct = 14;
   int   recv_idle_pct = 54;
   logic stim_done = 1'b0;
   result_type result_queue[$];

   v3a_req_if #(.WORD_BITS(W)) req_ch ();
   v3a_rsp_if #(.WORD_BITS(W)) rsp_ch ();

   vector3d_alu #(.WORD_BITS(W), .FRAC_BITS(F)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [127:0] rounded(input logic signed [127:0] x);
      return (x + (128'sd1 <<< (F - 1))) >>> F;
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] s);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         c = r | (64'd1 << bit_pos);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   function automatic result_type predict_alu(input op_type op);
      logic signed [127:0] r [3];
      logic signed [127:0] a [3];
      logic signed [127:0] b [3];
      logic signed [127:0] s;
      result_type res;
      for (int c = 0; c < 3; c++) begin
         a[c] = 128'(op.a[c]);
         b[c] = 128'(op.b[c]);
         r[c] = '0;
      end
      s = 128'(op.sf);
      case (op.mode)
         v3a_pkg::MODE_ADD: for (int c = 0; c < 3; c++) r[c] = a[c] + b[c];
         v3a_pkg::MODE_SUB: for (int c = 0; c < 3; c++) r[c] = a[c] - b[c];
         v3a_pkg::MODE_SCALE: for (int c = 0; c < 3; c++) r[c] = rounded(a[c] * s);
         v3a_pkg::MODE_DOT: r[0] = rounded(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
         v3a_pkg::MODE_CROSS: begin
            r[0] = rounded(a[1] * b[2] - a[2] * b[1]);
            r[1] = rounded(a[2] * b[0] - a[0] * b[2]);
            r[2] = rounded(a[0] * b[1] - a[1] * b[0]);
         end
         v3a_pkg::MODE_MAG: r[0] = 128'(root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
         v3a_pkg::MODE_DIST: begin
            for (int c = 0; c < 3; c++) b[c] = a[c] - b[c];
            r[0] = 128'(root_floor(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]));
         end
         default: ;
      endcase
      res.sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (r[c] > WMAX) begin
            res.v[c] = WMAX;
            res.sat = 1'b1;
         end else if (r[c] < WMIN) begin
            res.v[c] = WMIN;
            res.sat = 1'b1;
         end else begin
            res.v[c] = r[c][W-1:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                  input logic [W-1:0] want);
      $display("mismatch %0s: got %h, expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic logic signed [W-1:0] random_word();
      case ($urandom_range(0, 5))
         0: return WMAX;
         1: return WMIN;
         2: return $signed(W'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
         3: return $signed(W'($urandom_range(0, 32'h1ffffff))) - 32'sh1000000;
         default: return $signed(W'($urandom));
      endcase
   endfunction

   function automatic op_type make_op(input logic [2:0] mode,
                                      input logic signed [W-1:0] av,
                                      input logic signed [W-1:0] bv,
                                      input logic signed [W-1:0] sf);
      op_type op;
      op.mode = mode;
      op.sf = sf;
      for (int c = 0; c < 3; c++) begin
         op.a[c] = av;
         op.b[c] = bv;
      end
      return op;
   endfunction

   function automatic row_type row(input op_type op, input logic known,
                                   input logic signed [W-1:0] ri,
                                   input logic signed [W-1:0] rj,
                                   input logic signed [W-1:0] rk, input logic sat);
      row_type t;
      t.op = op;
      t.known = known;
      t.res.v[0] = ri;
      t.res.v[1] = rj;
      t.res.v[2] = rk;
      t.res.sat = sat;
      return t;
   endfunction

   task automatic send_item(input op_type op, input logic known, input result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= op.mode;
      req_ch.a_i <= op.a[0];
      req_ch.a_j <= op.a[1];
      req_ch.a_k <= op.a[2];
      req_ch.b_i <= op.b[0];
      req_ch.b_j <= op.b[1];
      req_ch.b_k <= op.b[2];
      req_ch.scale_factor <= op.sf;
      do @(posedge clock); while (!req_ch.ready);
      result_queue.push_back(known ? want : predict_alu(op));
   endtask

   function automatic op_type random_op();
      op_type op;
      op.mode = 3'($urandom_range(0, 7));
      op.sf = random_word();
      for (int c = 0; c < 3; c++) begin
         op.a[c] = random_word();
         op.b[c] = random_word();
      end
      if ($urandom_range(0, 9) == 0) begin
         op.a[2] = '0;
         op.b[2] = '0;
      end
      return op;
   endfunction

   initial begin
      row_type    directed [$];
      result_type none;
      none = '{v: '{0, 0, 0}, sat: 1'b0};
      req_ch.valid = 1'b0;
      req_ch.mode = v3a_pkg::MODE_ADD;
      {req_ch.a_i, req_ch.a_j, req_ch.a_k} = '0;
      {req_ch.b_i, req_ch.b_j, req_ch.b_k} = '0;
      req_ch.scale_factor = '0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(row(make_op(v3a_pkg::MODE_ADD, 0, 0, 0), 1'b1, 0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_ADD, WMAX, 1, 0), 1'b1,
                             WMAX, WMAX, WMAX, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_SUB, WMIN, 1, 0), 1'b1,
                             WMIN, WMIN, WMIN, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_SUB, WMAX, WMIN, 0), 1'b1,
                             WMAX, WMAX, WMAX, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_ADD, -1, 1, 0), 1'b1, 0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_SCALE, 32'sh10000, 0, 32'sh10000), 1'b1,
                             32'sh10000, 32'sh10000, 32'sh10000, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_SCALE, WMIN, 0, WMIN), 1'b1,
                             WMAX, WMAX, WMAX, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_SCALE, WMAX, 0, WMIN), 1'b1,
                             WMIN, WMIN, WMIN, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_SCALE, 1, 0, 32'sh8000), 1'b0,
                             0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_SCALE, -1, 0, 32'sh8000), 1'b0,
                             0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_DOT, 32'sh10000, 32'sh20000, 0), 1'b1,
                             32'sh60000, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_DOT, WMAX, WMAX, 0), 1'b1,
                             WMAX, 0, 0, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_DOT, WMIN, WMAX, 0), 1'b1,
                             WMIN, 0, 0, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_CROSS, 32'sh30000, 32'sh30000, 0), 1'b1,
                             0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_CROSS, 32'sh1234, -32'sh777, 0), 1'b0,
                             0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_MAG, 0, 0, 0), 1'b1, 0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_MAG, WMIN, 0, 0), 1'b1,
                             WMAX, 0, 0, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_MAG, 32'sh10000, 0, 0), 1'b0,
                             0, 0, 0, 1'b0));
      directed.push_back(row(make_op(v3a_pkg::MODE_DIST, WMAX, WMIN, 0), 1'b1,
                             WMAX, 0, 0, 1'b1));
      directed.push_back(row(make_op(v3a_pkg::MODE_DIST, 5, 5, 0), 1'b1, 0, 0, 0, 1'b0));
      directed.push_back(row(make_op(3'd7, WMAX, WMIN, WMIN), 1'b1, 0, 0, 0, 1'b0));
      begin
         row_type t;
         t = row(make_op(v3a_pkg::MODE_CROSS, 0, 0, 0), 1'b0, 0, 0, 0, 1'b0);
         t.op.a = '{32'sh10000, 0, 0};
         t.op.b = '{0, 32'sh10000, 0};
         t.known = 1'b1;
         t.res = '{v: '{0, 0, 32'sh10000}, sat: 1'b0};
         directed.push_back(t);
         t.op.mode = v3a_pkg::MODE_MAG;
         t.op.a = '{32'sh30000, 32'sh40000, 0};
         t.res = '{v: '{32'sh50000, 0, 0}, sat: 1'b0};
         directed.push_back(t);
      end
      foreach (directed[n]) send_item(directed[n].op, directed[n].known, directed[n].res);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 14 : 0;
         repeat (580) send_item(random_op(), 1'b0, none);
      end
      req_ch.valid <= 1'b0;
      stim_done <= 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (result_queue.size() == 0) begin
            $display("unexpected transfer at cycle %0d", cycles);
            errors++;
         end else begin
            want = result_queue.pop_front();
            if (rsp_ch.out_i !== want.v[0]) report_mismatch("out_i", rsp_ch.out_i, want.v[0]);
            if (rsp_ch.out_j !== want.v[1]) report_mismatch("out_j", rsp_ch.out_j, want.v[1]);
            if (rsp_ch.out_k !== want.v[2]) report_mismatch("out_k", rsp_ch.out_k, want.v[2]);
            if (rsp_ch.saturated !== want.sat)
               report_mismatch("saturated", W'(rsp_ch.saturated), W'(want.sat));
         end
      end
   end

   initial begin
      int drain;
      drain = 0;
      while (!(stim_done && result_queue.size() == 0 && drain >= 2 * LATENCY)
             && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
         if (stim_done && result_queue.size() == 0) drain++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("simulation failed");
      end else if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
